/* design/gbs_pkg.sv */
`timescale 1ns / 1ps
package gbs_pkg;

   localparam int MAX_POINTS   = 4096;
   localparam int MAX_DIM      = 128;
   localparam int MAX_DEGREE   = 64;
   localparam int MAX_LIST     = 128;
   localparam int RESULT_LIMIT = 64;

   localparam int PT_W   = $clog2(MAX_POINTS);
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEG_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int LIST_W = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
   localparam int RES_W  = $clog2(RESULT_LIMIT);

   localparam int VEC_DEPTH = MAX_POINTS * MAX_DIM;
   localparam int ADJ_DEPTH = MAX_POINTS * MAX_DEGREE;

   localparam int DIST_W = 40;
   localparam int SQ_W   = 32;
   localparam int CMP_W  = 13;
   localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
   localparam logic [CMP_W-1:0]  CMP_SAT  = {CMP_W{1'b1}};

   typedef enum logic [1:0] {
      MODE_VECTOR = 2'd0,
      MODE_EDGE   = 2'd1,
      MODE_DEGREE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   localparam logic [1:0] CSR_START_NODE   = 2'd0;
   localparam logic [1:0] CSR_LIST_SIZE    = 2'd1;
   localparam logic [1:0] CSR_RESULT_COUNT = 2'd2;
   localparam logic [1:0] CSR_DIMS_IN_USE  = 2'd3;

   typedef struct packed {
      logic              expanded;
      logic [PT_W-1:0]   id;
      logic [DIST_W-1:0] distance;
   } cand_type;

   localparam int CAND_W = $bits(cand_type);

endpackage

/* design/gbs_ram.sv */
`timescale 1ns / 1ps
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/graph_greedy_beam_search_unit.sv */
`timescale 1ns / 1ps
// Best-first graph search engine. Load words (mode 0..2) write the vector, adjacency and degree
// tables; query words fill the query buffer, one per cycle while req_stall is low. A query word
// with last set starts the search: the visited map is swept clear, then every distance
// (dims_in_use capped at 128) is formed on the single shared subtract-square-accumulate unit,
// each list insertion moves farther entries back one place, and each expansion scans the
// candidate list for the first unexpanded entry and then visits each of its neighbor slots.
// Results leave one word at a time, each held until it is taken.
// After reset the degree table and visited map are cleared with req_stall high;
// configuration writes are taken at any time but should only be made while the block is idle.
module graph_greedy_beam_search_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_point,
   input  logic [6:0]  req_position,
   input  logic signed [15:0] req_value,
   input  logic [11:0] req_neighbor,
   input  logic [6:0]  req_degree,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_result_id,
   output logic [39:0] rsp_result_distance,
   output logic [5:0]  rsp_rank,
   output logic [12:0] rsp_comparisons,
   output logic        rsp_last_result
);
   import gbs_pkg::*;

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_VCLR, ST_MARK, ST_DIST, ST_INS0, ST_INSCHK, ST_INSRD, ST_INSCMP,
      ST_PICK, ST_PICKCHK, ST_DEG, ST_SLOT, ST_ADJ, ST_VIS, ST_ORD, ST_OSHOW, ST_OWAIT
   } state_type;

   state_type state_ff;
   logic [PT_W-1:0]   cnt_ff;
   logic [11:0]       start_ff;
   logic [7:0]        lsize_ff;
   logic [6:0]        rcount_ff;
   logic [7:0]        dims_ff;
   logic [RES_W:0]    kval_ff;
   logic [LIST_W:0]   bound_ff;
   logic [DIM_W:0]    ndims_ff;
   logic [PT_W-1:0]   node_ff;
   logic [DIM_W:0]    dim_ff;
   logic              rdv_ff;
   logic              sqv_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [DIST_W-1:0] acc_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [LIST_W:0]   ccount_ff;
   logic [CMP_W-1:0]  cmp_ff;
   logic [LIST_W:0]   idx_ff;
   logic              first_ff;
   logic [PT_W-1:0]   best_ff;
   logic [DEG_W:0]    deg_ff;
   logic [DEG_W:0]    slot_ff;
   logic [LIST_W:0]   nres_ff;
   logic [LIST_W:0]   rank_ff;
   logic              rsp_valid_ff;
   logic [11:0]       rsp_id_ff;
   logic [39:0]       rsp_dist_ff;
   logic [5:0]        rsp_rank_ff;
   logic [12:0]       rsp_cmp_ff;
   logic              rsp_last_ff;

   // memory ports
   logic                             vec_we;
   logic [$clog2(VEC_DEPTH)-1:0]     vec_waddr, vec_raddr;
   logic [15:0]                      vec_rdata;
   logic                             adj_we;
   logic [$clog2(ADJ_DEPTH)-1:0]     adj_waddr, adj_raddr;
   logic [PT_W-1:0]                  adj_rdata;
   logic                             deg_we;
   logic [PT_W-1:0]                  deg_waddr, deg_raddr;
   logic [DEG_W:0]                   deg_wdata, deg_rdata;
   logic                             vis_we;
   logic [PT_W-1:0]                  vis_waddr, vis_raddr;
   logic                             vis_wdata, vis_rdata;
   logic                             qry_we;
   logic [DIM_W-1:0]                 qry_waddr, qry_raddr;
   logic [15:0]                      qry_rdata;
   logic                             cand_we;
   logic [LIST_W-1:0]                cand_waddr, cand_raddr;
   cand_type                         cand_wdata, cand_rd;
   logic [CAND_W-1:0]                cand_rdata;

   logic              accept;
   logic              issue;
   logic              gt;
   cand_type          new_cand;
   logic [RES_W:0]    k_calc;
   logic [LIST_W:0]   bound_calc;
   logic [DIM_W:0]    ndims_calc;
   logic signed [16:0] diff;
   logic signed [33:0] prod;
   logic [DIST_W:0]   acc_sum;
   logic [DEG_W:0]    deg_sat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cand_rd   = cand_type'(cand_rdata);
   assign new_cand  = '{expanded: 1'b0, id: node_ff, distance: dist_ff};
   assign gt        = (cand_rd.distance > dist_ff)
                      || (cand_rd.distance == dist_ff && cand_rd.id > node_ff);
   assign issue     = (dim_ff < ndims_ff);

   assign diff    = $signed({qry_rdata[15], qry_rdata}) - $signed({vec_rdata[15], vec_rdata});
   assign prod    = diff * diff;
   assign acc_sum = {1'b0, acc_ff} + (DIST_W + 1)'(sq_ff);
   assign deg_sat = (req_degree > 7'(MAX_DEGREE)) ? (DEG_W + 1)'(MAX_DEGREE)
                                                  : (DEG_W + 1)'(req_degree);

   always_comb begin
      logic [7:0] kb;
      if (rcount_ff == 7'd0) begin
         k_calc = (RES_W + 1)'(1);
      end else if (rcount_ff > 7'(RESULT_LIMIT)) begin
         k_calc = (RES_W + 1)'(RESULT_LIMIT);
      end else begin
         k_calc = (RES_W + 1)'(rcount_ff);
      end
      kb = (lsize_ff > 8'(k_calc)) ? lsize_ff : 8'(k_calc);
      if (kb > 8'(MAX_LIST)) begin
         bound_calc = (LIST_W + 1)'(MAX_LIST);
      end else begin
         bound_calc = (LIST_W + 1)'(kb);
      end
      ndims_calc = (dims_ff > 8'(MAX_DIM)) ? (DIM_W + 1)'(MAX_DIM) : (DIM_W + 1)'(dims_ff);
   end

   always_comb begin
      vec_we     = 1'b0;
      vec_waddr  = {req_point[PT_W-1:0], req_position[DIM_W-1:0]};
      vec_raddr  = {node_ff, dim_ff[DIM_W-1:0]};
      adj_we     = 1'b0;
      adj_waddr  = {req_point[PT_W-1:0], req_position[DEG_W-1:0]};
      adj_raddr  = {best_ff, slot_ff[DEG_W-1:0]};
      deg_we     = 1'b0;
      deg_waddr  = cnt_ff;
      deg_wdata  = '0;
      deg_raddr  = cand_rd.id;
      vis_we     = 1'b0;
      vis_waddr  = cnt_ff;
      vis_wdata  = 1'b0;
      vis_raddr  = adj_rdata;
      qry_we     = 1'b0;
      qry_waddr  = req_position[DIM_W-1:0];
      qry_raddr  = dim_ff[DIM_W-1:0];
      cand_we    = 1'b0;
      cand_waddr = idx_ff[LIST_W-1:0];
      cand_wdata = new_cand;
      cand_raddr = idx_ff[LIST_W-1:0];
      case (state_ff)
         ST_CLR: begin
            deg_we = 1'b1;
            vis_we = 1'b1;
         end
         ST_IDLE: begin
            case (mode_type'(req_mode))
               MODE_VECTOR: vec_we = accept && (int'(req_position) < MAX_DIM)
                                     && (int'(req_point) < MAX_POINTS);
               MODE_EDGE: adj_we = accept && (int'(req_position) < MAX_DEGREE)
                                   && (int'(req_point) < MAX_POINTS)
                                   && (int'(req_neighbor) < MAX_POINTS);
               MODE_DEGREE: begin
                  deg_we    = accept && (int'(req_point) < MAX_POINTS);
                  deg_waddr = req_point[PT_W-1:0];
                  deg_wdata = deg_sat;
               end
               MODE_QUERY: qry_we = accept && (int'(req_position) < MAX_DIM);
               default: ;
            endcase
         end
         ST_VCLR: vis_we = 1'b1;
         ST_MARK: begin
            vis_we    = 1'b1;
            vis_waddr = node_ff;
            vis_wdata = 1'b1;
         end
         ST_INS0: cand_raddr = LIST_W'(ccount_ff - 1'b1);
         ST_INSRD: begin
            if (idx_ff == '0) begin
               cand_we = 1'b1;
            end else begin
               cand_raddr = LIST_W'(idx_ff - 1'b1);
            end
         end
         ST_INSCMP: begin
            cand_we = 1'b1;
            if (gt) begin
               cand_wdata = cand_rd;
            end
         end
         ST_PICKCHK: begin
            if (!cand_rd.expanded) begin
               cand_we    = 1'b1;
               cand_wdata = '{expanded: 1'b1, id: cand_rd.id, distance: cand_rd.distance};
            end
         end
         ST_ORD: cand_raddr = rank_ff[LIST_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         start_ff     <= '0;
         lsize_ff     <= 8'd64;
         rcount_ff    <= 7'd10;
         dims_ff      <= 8'd128;
         ccount_ff    <= '0;
         cmp_ff       <= '0;
         rdv_ff       <= 1'b0;
         sqv_ff       <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_NODE:   start_ff  <= csr_data;
               CSR_LIST_SIZE:    lsize_ff  <= csr_data[7:0];
               CSR_RESULT_COUNT: rcount_ff <= csr_data[6:0];
               CSR_DIMS_IN_USE:  dims_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_CLR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == PT_W'(MAX_POINTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && mode_type'(req_mode) == MODE_QUERY && req_last) begin
                  kval_ff  <= k_calc;
                  bound_ff <= bound_calc;
                  ndims_ff <= ndims_calc;
                  cnt_ff   <= '0;
                  state_ff <= ST_VCLR;
               end
            end
            ST_VCLR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == PT_W'(MAX_POINTS - 1)) begin
                  node_ff   <= start_ff[PT_W-1:0];
                  ccount_ff <= '0;
                  cmp_ff    <= '0;
                  first_ff  <= 1'b1;
                  state_ff  <= ST_MARK;
               end
            end
            ST_MARK: begin
               dim_ff   <= '0;
               acc_ff   <= '0;
               rdv_ff   <= 1'b0;
               sqv_ff   <= 1'b0;
               state_ff <= ST_DIST;
            end
            ST_DIST: begin
               if (issue) begin
                  dim_ff <= dim_ff + 1'b1;
               end
               rdv_ff <= issue;
               sq_ff  <= prod[SQ_W-1:0];
               sqv_ff <= rdv_ff;
               if (sqv_ff) begin
                  acc_ff <= acc_sum[DIST_W] ? DIST_SAT : acc_sum[DIST_W-1:0];
               end
               if (!issue && !rdv_ff && !sqv_ff) begin
                  dist_ff  <= acc_ff;
                  state_ff <= ST_INS0;
               end
            end
            ST_INS0: begin
               if (cmp_ff != CMP_SAT) begin
                  cmp_ff <= cmp_ff + 1'b1;
               end
               if (ccount_ff >= bound_ff) begin
                  state_ff <= ST_INSCHK;
               end else begin
                  idx_ff   <= ccount_ff;
                  state_ff <= ST_INSRD;
               end
            end
            ST_INSCHK: begin
               // full list: only a strictly nearer node displaces the worst entry
               if (dist_ff >= cand_rd.distance) begin
                  state_ff <= first_ff ? ST_PICK : ST_SLOT;
                  first_ff <= 1'b0;
                  idx_ff   <= '0;
               end else begin
                  ccount_ff <= ccount_ff - 1'b1;
                  idx_ff    <= ccount_ff - 1'b1;
                  state_ff  <= ST_INSRD;
               end
            end
            ST_INSRD: begin
               if (idx_ff == '0) begin
                  ccount_ff <= ccount_ff + 1'b1;
                  state_ff  <= first_ff ? ST_PICK : ST_SLOT;
                  first_ff  <= 1'b0;
               end else begin
                  state_ff <= ST_INSCMP;
               end
            end
            ST_INSCMP: begin
               if (gt) begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= ST_INSRD;
               end else begin
                  ccount_ff <= ccount_ff + 1'b1;
                  idx_ff    <= '0;
                  state_ff  <= first_ff ? ST_PICK : ST_SLOT;
                  first_ff  <= 1'b0;
               end
            end
            ST_PICK: begin
               if (idx_ff >= ccount_ff) begin
                  nres_ff  <= (ccount_ff < (LIST_W + 1)'(kval_ff)) ? ccount_ff
                                                                   : (LIST_W + 1)'(kval_ff);
                  rank_ff  <= '0;
                  state_ff <= ST_ORD;
               end else begin
                  state_ff <= ST_PICKCHK;
               end
            end
            ST_PICKCHK: begin
               if (cand_rd.expanded) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_PICK;
               end else begin
                  best_ff  <= cand_rd.id;
                  state_ff <= ST_DEG;
               end
            end
            ST_DEG: begin
               deg_ff   <= deg_rdata;
               slot_ff  <= '0;
               state_ff <= ST_SLOT;
            end
            ST_SLOT: begin
               if (slot_ff < deg_ff) begin
                  slot_ff  <= slot_ff + 1'b1;
                  state_ff <= ST_ADJ;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_PICK;
               end
            end
            ST_ADJ: begin
               node_ff  <= adj_rdata;
               state_ff <= ST_VIS;
            end
            ST_VIS: begin
               state_ff <= vis_rdata ? ST_SLOT : ST_MARK;
            end
            ST_ORD: state_ff <= ST_OSHOW;
            ST_OSHOW: begin
               rsp_valid_ff <= 1'b1;
               rsp_id_ff    <= 12'(cand_rd.id);
               rsp_dist_ff  <= cand_rd.distance;
               rsp_rank_ff  <= rank_ff[5:0];
               rsp_cmp_ff   <= cmp_ff;
               rsp_last_ff  <= (rank_ff + 1'b1 == nres_ff);
               state_ff     <= ST_OWAIT;
            end
            ST_OWAIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  rank_ff      <= rank_ff + 1'b1;
                  state_ff     <= rsp_last_ff ? ST_IDLE : ST_ORD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_id       = rsp_id_ff;
   assign rsp_result_distance = rsp_dist_ff;
   assign rsp_rank            = rsp_rank_ff;
   assign rsp_comparisons     = rsp_cmp_ff;
   assign rsp_last_result     = rsp_last_ff;

   gbs_ram #(.WIDTH(16), .DEPTH(VEC_DEPTH)) u_vec (
      .clock(clock), .we(vec_we), .waddr(vec_waddr), .wdata(req_value),
      .raddr(vec_raddr), .rdata(vec_rdata)
   );

   gbs_ram #(.WIDTH(PT_W), .DEPTH(ADJ_DEPTH)) u_adj (
      .clock(clock), .we(adj_we), .waddr(adj_waddr), .wdata(req_neighbor[PT_W-1:0]),
      .raddr(adj_raddr), .rdata(adj_rdata)
   );

   gbs_ram #(.WIDTH(DEG_W + 1), .DEPTH(MAX_POINTS)) u_deg (
      .clock(clock), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
      .raddr(deg_raddr), .rdata(deg_rdata)
   );

   gbs_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_vis (
      .clock(clock), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
      .raddr(vis_raddr), .rdata(vis_rdata)
   );

   gbs_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_qry (
      .clock(clock), .we(qry_we), .waddr(qry_waddr), .wdata(req_value),
      .raddr(qry_raddr), .rdata(qry_rdata)
   );

   gbs_ram #(.WIDTH(CAND_W), .DEPTH(MAX_LIST)) u_cand (
      .clock(clock), .we(cand_we), .waddr(cand_waddr), .wdata(cand_wdata),
      .raddr(cand_raddr), .rdata(cand_rdata)
   );

endmodule

/* design/gbs_check.sv */
`timescale 1ns / 1ps
module gbs_check (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_result_id,
   input logic [12:0] rsp_comparisons
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_id))
      else $error("result word changed under stall");

   // no new input word while results of a query are pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   // every search counts at least the start node
   a_cmp_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_comparisons != 13'd0)
      else $error("zero comparison count on a result");

   // the table clear after reset keeps the input closed
   a_rst_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall && !rsp_valid)
      else $error("block open right after reset");

endmodule

bind graph_greedy_beam_search_unit gbs_check u_gbs_check (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_result_id(rsp_result_id), .rsp_comparisons(rsp_comparisons)
);
